// ----- hdl/tmos_pkg.sv -----
// ----------------------------------------------------------------------------
// tmos_pkg: shared types and constants for the trimmed mean of a set
// Widths of the set statistics, the count limit, the floor reset value and
// the sequencer state encoding.
// ----------------------------------------------------------------------------
package tmos_pkg;

  localparam int unsigned VALUE_W   = 32;  // Q16.16 sample and result
  localparam int unsigned FLOOR_W   = 16;  // floor register, fraction part only
  localparam int unsigned CNT_W     = 8;   // qualifying count
  localparam int unsigned SUM_W     = 40;  // running sum of up to 255 samples
  localparam int unsigned REM_W     = CNT_W + 1;  // divider partial remainder
  localparam int unsigned STEP_W    = 6;   // divider step counter
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [CNT_W-1:0]   COUNT_LIMIT = 8'd255;
  localparam logic [FLOOR_W-1:0] FLOOR_RESET = 16'd66;
  localparam logic [STEP_W-1:0]  DIV_LAST_STEP = STEP_W'(SUM_W - 1);
  localparam logic [CNT_W-1:0]   TRIM_MIN_CNT = 8'd3;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_ACCUM,     // take samples, one per cycle
    ST_TRIM_MIN,  // sum minus minimum
    ST_TRIM_MAX,  // minus maximum
    ST_DIV,       // one quotient bit per cycle
    ST_DONE       // hand result to the output register
  } tmos_state_t;

endpackage

// ----- hdl/trimmed_mean_of_set.sv -----
// ----------------------------------------------------------------------------
// trimmed_mean_of_set: Olympic average of a set of Q16.16 samples
// Keeps count, minimum, maximum and sum of qualifying samples; on the last
// sample of a set with three or more removes one minimum and one maximum with
// a shared subtractor and divides by count - 2 under a small sequencer.
//
//  Channel  Dir  Fields (low bit up)                           Transfer
//  in_      in   tdata: value[31:0]; tuser: is_valid; tlast    tvalid & tready
//  out_     out  tdata: canonical_value[31:0],                 tvalid & tready
//                       qualified_count[39:32]
//  cfg_     in   wr_data: floor_value[15:0]                    wr_en
//
//  With at most two qualifying samples, a last sample yields the minimum (the
//  floor if none qualified) and goes straight to the done state; else the sum
//  takes two passes through the 40-bit subtractor, then one restoring-division
//  step per quotient bit. The done state moves the result into the output
//  register once free, to wait for out_tready; the next set may stream in.
//  Reset is synchronous, active low, and clears the set and sets the floor
//  to 66 (about 0.001).
// ----------------------------------------------------------------------------
module trimmed_mean_of_set (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [tmos_pkg::IN_DATA_W-1:0] in_tdata,   // value[31:0]
  input  logic                           in_tuser,   // is_valid
  input  logic                           in_tlast,   // last
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [tmos_pkg::OUT_DATA_W-1:0] out_tdata, // canonical_value[31:0],
                                                     // qualified_count[39:32]
  // configuration
  input  logic                           cfg_wr_en,
  input  logic [tmos_pkg::FLOOR_W-1:0]   cfg_wr_data // floor_value[15:0]
);
  import tmos_pkg::*;

  tmos_state_t          state_r, state_nxt;
  logic [FLOOR_W-1:0]   floor_r;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [VALUE_W-1:0]   min_r, min_nxt;
  logic [VALUE_W-1:0]   max_r, max_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [SUM_W-1:0]     quo_r, quo_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic [VALUE_W-1:0]   res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic [VALUE_W-1:0]   in_value;
  logic                 in_xfer;
  logic                 qualifies;
  logic [SUM_W-1:0]     sub_a, sub_diff;
  logic [VALUE_W-1:0]   sub_b;
  logic [CNT_W-1:0]     divisor;
  logic [REM_W-1:0]     rem_shift, rem_diff;
  logic                 rem_ge;

  assign in_value  = in_tdata[VALUE_W-1:0];
  assign in_tready = (state_r == ST_ACCUM);
  assign in_xfer   = in_tvalid && in_tready;
  assign qualifies = in_tuser && (in_value >= {{(VALUE_W-FLOOR_W){1'b0}}, floor_r});

  // Shared trim subtractor
  assign sub_a    = (state_r == ST_TRIM_MIN) ? sum_r : quo_r;
  assign sub_b    = (state_r == ST_TRIM_MIN) ? min_r : max_r;
  assign sub_diff = sub_a - {{(SUM_W-VALUE_W){1'b0}}, sub_b};

  // Restoring division step
  assign divisor   = count_r - CNT_W'(2);
  assign rem_shift = {rem_r[REM_W-2:0], quo_r[SUM_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, divisor});
  assign rem_diff  = rem_shift - {1'b0, divisor};

  // Sequencer and datapath next state
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    sum_nxt       = sum_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // drop the result once the sink takes it
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_ACCUM: begin
        if (in_xfer) begin
          // fold in a qualifying sample until the count saturates
          if (qualifies && (count_r != COUNT_LIMIT)) begin
            count_nxt = count_r + CNT_W'(1);
            sum_nxt   = sum_r + {{(SUM_W-VALUE_W){1'b0}}, in_value};
            if (count_r == '0) begin
              min_nxt = in_value;
              max_nxt = in_value;
            end else begin
              if (in_value < min_r) min_nxt = in_value;
              if (in_value > max_r) max_nxt = in_value;
            end
          end
          if (in_tlast) begin
            if (count_nxt == '0) begin
              res_nxt   = {{(VALUE_W-FLOOR_W){1'b0}}, floor_r};
              state_nxt = ST_DONE;
            end else if (count_nxt < TRIM_MIN_CNT) begin
              res_nxt   = min_nxt;
              state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_TRIM_MIN;
            end
          end
        end
      end
      ST_TRIM_MIN: begin
        quo_nxt   = sub_diff;
        state_nxt = ST_TRIM_MAX;
      end
      ST_TRIM_MAX: begin
        quo_nxt   = sub_diff;
        rem_nxt   = '0;
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // shift in one quotient bit
        rem_nxt  = rem_ge ? rem_diff : rem_shift;
        quo_nxt  = {quo_r[SUM_W-2:0], rem_ge};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == DIV_LAST_STEP) begin
          res_nxt   = {quo_r[VALUE_W-2:0], rem_ge};
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // load the output register when free, then clear the set
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {count_r, res_r};
          count_nxt     = '0;
          min_nxt       = '0;
          max_nxt       = '0;
          sum_nxt       = '0;
          state_nxt     = ST_ACCUM;
        end
      end
      default: begin
        state_nxt = ST_ACCUM;
      end
    endcase
  end

  // Control and set state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACCUM;
      floor_r     <= FLOOR_RESET;
      count_r     <= '0;
      min_r       <= '0;
      max_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        floor_r <= cfg_wr_data;
      end
    end
  end

  // Divider and result payload
  always_ff @(posedge clk) begin
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    step_r     <= step_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- hdl/tmos_checker.sv -----
// ----------------------------------------------------------------------------
// tmos_checker: port-level checks for trimmed_mean_of_set
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module tmos_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            in_tlast,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tmos_pkg::OUT_DATA_W-1:0] out_tdata
);
  import tmos_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // The block is busy right after the last sample of a set
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("new sample taken right after end of set");

  // An empty set yields the 16-bit floor
  a_empty_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[OUT_DATA_W-1:VALUE_W] == '0)
      |-> (out_tdata[VALUE_W-1:FLOOR_W] == '0))
    else $error("empty set result exceeds floor width");

endmodule

bind trimmed_mean_of_set tmos_checker u_tmos_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
